/* hw/rtl/ofpc_pkg.sv */
// Shared types, constants and state encodings for the odd/even/prime filter counter.
package ofpc_pkg;

  // Width of the candidate value
  localparam int unsigned VALUE_BITS = 16;
  // Width of the match count
  localparam int unsigned COUNT_BITS = 16;
  // Bit counter width for the serial remainder unit (holds VALUE_BITS itself)
  localparam int unsigned STEP_BITS  = $clog2(VALUE_BITS + 1);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // Search mode register codes
  typedef enum logic [1:0] {
    MODE_ODD   = 2'd0,
    MODE_EVEN  = 2'd1,
    MODE_PRIME = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  // Input request
  typedef struct packed {
    logic signed [VALUE_BITS-1:0] candidate;
    logic                         range_start;
  } item_t;

  // Result payload
  typedef struct packed {
    logic signed [VALUE_BITS-1:0] echoed_value;
    logic                         is_match;
    logic [COUNT_BITS-1:0]        match_total;
  } result_t;

  // Remainder unit request and response
  typedef struct packed {
    logic                  start;
    logic [VALUE_BITS-1:0] dividend;
    logic [VALUE_BITS-1:0] divisor;
  } rem_req_t;

  typedef struct packed {
    logic                  done;
    logic [VALUE_BITS-1:0] remainder;
  } rem_rsp_t;

  // Primality sequencer request and response
  typedef struct packed {
    logic                  start;
    logic [VALUE_BITS-1:0] value;
  } prime_req_t;

  typedef struct packed {
    logic done;
    logic is_prime;
  } prime_rsp_t;

  // Primality sequencer states
  typedef enum logic [1:0] {
    PS_IDLE,
    PS_CHECK,
    PS_WAIT
  } prime_state_t;

  // Top level control states
  typedef enum logic [1:0] {
    TS_IDLE,
    TS_TEST,
    TS_LOAD
  } top_state_t;

endpackage

/* hw/rtl/ofpc_rem_serial.sv */
// Bit-serial restoring remainder unit: one dividend bit per cycle.
module ofpc_rem_serial (
  input  logic               clk,
  input  logic               rst,
  input  ofpc_pkg::rem_req_t req,
  output ofpc_pkg::rem_rsp_t rsp
);

  localparam int unsigned VB = ofpc_pkg::VALUE_BITS;
  localparam int unsigned SB = ofpc_pkg::STEP_BITS;

  logic          busy;
  logic          done;
  logic [SB-1:0] steps;
  logic [VB-1:0] dividend_sr;
  logic [VB-1:0] divisor;
  logic [VB-1:0] rem;

  // Shift in the next dividend bit and try the subtraction
  logic [VB:0] rem_shift;
  logic [VB:0] rem_diff;

  assign rem_shift = {rem, dividend_sr[VB-1]};
  assign rem_diff  = rem_shift - {1'b0, divisor};

  // Control: busy flag, step counter, done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        steps <= SB'(VB);
      end else if (busy) begin
        steps <= steps - SB'(1);
        if (steps == SB'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: dividend shift register and partial remainder
  always_ff @(posedge clk) begin
    if (req.start) begin
      dividend_sr <= req.dividend;
      divisor     <= req.divisor;
      rem         <= '0;
    end else if (busy) begin
      dividend_sr <= {dividend_sr[VB-2:0], 1'b0};
      if (!rem_diff[VB]) begin
        rem <= rem_diff[VB-1:0];
      end else begin
        rem <= rem_shift[VB-1:0];
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.remainder = rem;

endmodule

/* hw/rtl/ofpc_prime_seq.sv */
// Trial division sequencer: walks divisors while d*d <= value, one remainder per trial.
module ofpc_prime_seq (
  input  logic                 clk,
  input  logic                 rst,
  input  ofpc_pkg::prime_req_t req,
  output ofpc_pkg::prime_rsp_t rsp
);

  localparam int unsigned VB = ofpc_pkg::VALUE_BITS;

  ofpc_pkg::prime_state_t state, state_next;

  logic [VB-1:0] value;
  logic [VB-1:0] divisor;
  logic [VB-1:0] square;
  logic          done;
  logic          is_prime;

  ofpc_pkg::rem_req_t rem_req;
  ofpc_pkg::rem_rsp_t rem_rsp;

  // Control decodes
  logic load;
  logic step;
  logic finish;
  logic finish_prime;

  ofpc_rem_serial u_rem (
    .clk (clk),
    .rst (rst),
    .req (rem_req),
    .rsp (rem_rsp)
  );

  assign rem_req.dividend = value;
  assign rem_req.divisor  = divisor;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ofpc_pkg::PS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and controls
  always_comb begin
    state_next    = state;
    load          = 1'b0;
    step          = 1'b0;
    finish        = 1'b0;
    finish_prime  = 1'b0;
    rem_req.start = 1'b0;
    unique case (state)
      ofpc_pkg::PS_IDLE: begin
        if (req.start) begin
          if (req.value < VB'(2)) begin
            finish = 1'b1;
          end else begin
            load       = 1'b1;
            state_next = ofpc_pkg::PS_CHECK;
          end
        end
      end
      ofpc_pkg::PS_CHECK: begin
        if (square > value) begin
          finish       = 1'b1;
          finish_prime = 1'b1;
          state_next   = ofpc_pkg::PS_IDLE;
        end else begin
          rem_req.start = 1'b1;
          state_next    = ofpc_pkg::PS_WAIT;
        end
      end
      ofpc_pkg::PS_WAIT: begin
        if (rem_rsp.done) begin
          if (rem_rsp.remainder == '0) begin
            finish     = 1'b1;
            state_next = ofpc_pkg::PS_IDLE;
          end else begin
            step       = 1'b1;
            state_next = ofpc_pkg::PS_CHECK;
          end
        end
      end
      default: state_next = ofpc_pkg::PS_IDLE;
    endcase
  end

  // Divisor and its square; (d+1)^2 = d^2 + 2d + 1
  always_ff @(posedge clk) begin
    if (load) begin
      value   <= req.value;
      divisor <= VB'(2);
      square  <= VB'(4);
    end else if (step) begin
      divisor <= divisor + VB'(1);
      square  <= square + {divisor[VB-2:0], 1'b1};
    end
  end

  // Completion pulse and verdict
  always_ff @(posedge clk) begin
    if (rst) begin
      done     <= 1'b0;
      is_prime <= 1'b0;
    end else begin
      done <= finish;
      if (finish) begin
        is_prime <= finish_prime;
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.is_prime = is_prime;

endmodule

/* hw/rtl/odd_even_prime_filter_counter_unit.sv */
// Top level: handshakes, mode register, match decision and saturating match count.
//
//  channel   direction  handshake            payload
//  item      in         item_valid/stall     ofpc_pkg::item_t
//  result    out        result_valid/stall   ofpc_pkg::result_t
//  cfg       in         cfg_valid/ready      search mode (2 bits)
//
// Odd, even, unused modes and negative values: held in TS_LOAD until the output
// register can take the result. Prime mode: each trial divisor is one run of the
// serial remainder unit; up to about sqrt(value) trials.
// One request at a time; a new request is taken once the previous result sits
// in the output register, even while that result is stalled.
// rst is synchronous; it clears the mode to odd and the match count to zero.
module odd_even_prime_filter_counter_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  ofpc_pkg::item_t     item,
  output logic                result_valid,
  input  logic                result_stall,
  output ofpc_pkg::result_t   result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_data
);

  localparam int unsigned VB = ofpc_pkg::VALUE_BITS;
  localparam int unsigned CB = ofpc_pkg::COUNT_BITS;

  ofpc_pkg::top_state_t state, state_next;
  ofpc_pkg::mode_t      mode;

  logic [CB-1:0]        match_count;
  logic signed [VB-1:0] hold_value;
  logic                 hold_range;
  logic                 hold_match;

  ofpc_pkg::prime_req_t prime_req;
  ofpc_pkg::prime_rsp_t prime_rsp;

  logic accept;
  logic load_out;
  logic quick_match;
  logic negative;

  logic [CB-1:0] count_base;
  logic [CB-1:0] count_new;

  ofpc_prime_seq u_prime (
    .clk (clk),
    .rst (rst),
    .req (prime_req),
    .rsp (prime_rsp)
  );

  assign cfg_ready  = 1'b1;
  assign item_stall = (state != ofpc_pkg::TS_IDLE);
  assign accept     = item_valid && !item_stall;
  assign negative   = item.candidate[VB-1];

  // Mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= ofpc_pkg::MODE_ODD;
    end else if (cfg_valid && cfg_ready) begin
      mode <= ofpc_pkg::mode_t'(cfg_data);
    end
  end

  // Direct decision for odd and even modes
  always_comb begin
    unique case (mode)
      ofpc_pkg::MODE_ODD:  quick_match = !negative && item.candidate[0];
      ofpc_pkg::MODE_EVEN: quick_match = !negative && !item.candidate[0];
      default:             quick_match = 1'b0;
    endcase
  end

  assign prime_req.start = accept && (mode == ofpc_pkg::MODE_PRIME) && !negative;
  assign prime_req.value = item.candidate;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ofpc_pkg::TS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and output load
  always_comb begin
    state_next = state;
    load_out   = 1'b0;
    unique case (state)
      ofpc_pkg::TS_IDLE: begin
        if (prime_req.start) begin
          state_next = ofpc_pkg::TS_TEST;
        end else if (accept) begin
          state_next = ofpc_pkg::TS_LOAD;
        end
      end
      ofpc_pkg::TS_TEST: begin
        if (prime_rsp.done) begin
          state_next = ofpc_pkg::TS_LOAD;
        end
      end
      ofpc_pkg::TS_LOAD: begin
        if (!result_valid || !result_stall) begin
          load_out   = 1'b1;
          state_next = ofpc_pkg::TS_IDLE;
        end
      end
      default: state_next = ofpc_pkg::TS_IDLE;
    endcase
  end

  // Held request and match verdict
  always_ff @(posedge clk) begin
    if (accept) begin
      hold_value <= item.candidate;
      hold_range <= item.range_start;
      hold_match <= quick_match;
    end else if (state == ofpc_pkg::TS_TEST && prime_rsp.done) begin
      hold_match <= prime_rsp.is_prime;
    end
  end

  // Saturating count, cleared first by range start
  assign count_base = hold_range ? '0 : match_count;
  assign count_new  = (hold_match && count_base != ofpc_pkg::COUNT_MAX) ?
                      count_base + CB'(1) : count_base;

  always_ff @(posedge clk) begin
    if (rst) begin
      match_count <= '0;
    end else if (load_out) begin
      match_count <= count_new;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      result.echoed_value <= hold_value;
      result.is_match     <= hold_match;
      result.match_total  <= count_new;
    end
  end

endmodule
